// ----- hdl/txtrle_pkg.sv -----
package txtrle_pkg;

  // Decimal counts never exceed five digits, so 17 bits hold every run length.
  localparam int DEC_W       = 17;
  localparam int DIGIT_CAP   = 99999;
  localparam int COUNT_WIDTH = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // One queue entry holds everything a single input beat asks the back end to emit:
  // an optional closed run and an optional final run of the message.
  typedef struct packed {
    logic               close_v;
    logic [7:0]         close_sym;
    logic [DEC_W-1:0]   close_len;
    logic               fin_v;
    logic [7:0]         fin_sym;
    logic [DEC_W-1:0]   fin_len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [DEC_W-1:0] pow10(input logic [2:0] place);
    logic [DEC_W-1:0] p;
    case (place)
      3'd0:    p = DEC_W'(1);
      3'd1:    p = DEC_W'(10);
      3'd2:    p = DEC_W'(100);
      3'd3:    p = DEC_W'(1000);
      3'd4:    p = DEC_W'(10000);
      default: p = DEC_W'(1);
    endcase
    return p;
  endfunction

  // Place of the most significant nonzero digit; zero for single-digit values.
  function automatic logic [2:0] lead_place(input logic [DEC_W-1:0] v);
    logic [2:0] p;
    if (v >= DEC_W'(10000)) begin
      p = 3'd4;
    end else if (v >= DEC_W'(1000)) begin
      p = 3'd3;
    end else if (v >= DEC_W'(100)) begin
      p = 3'd2;
    end else if (v >= DEC_W'(10)) begin
      p = 3'd1;
    end else begin
      p = 3'd0;
    end
    return p;
  endfunction

endpackage

// ----- hdl/txtrle_if.sv -----
interface txtrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface txtrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_end;

  modport source (output valid, output out_byte, output out_last, output out_end, input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_end, output ready);
endinterface

// ----- hdl/txtrle_front.sv -----
module txtrle_front #(
  parameter int CountWidth = txtrle_pkg::COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  txtrle_in_if.sink           in_ch,
  input  txtrle_pkg::qstat_t  q_stat,
  output logic                q_push,
  output txtrle_pkg::cmd_t    q_cmd
);

  localparam int DecW   = txtrle_pkg::DEC_W;
  localparam int LenW   = (CountWidth >= DecW) ? DecW : CountWidth;
  localparam int MaxRun = (CountWidth >= DecW) ? txtrle_pkg::DIGIT_CAP
                                               : (1 << CountWidth) - 1;

  logic [7:0]      run_sym_r, run_sym_nxt;
  logic [LenW-1:0] run_len_r, run_len_nxt;
  logic            run_open_r, run_open_nxt;

  logic            accept;
  logic            extend;
  logic [7:0]      new_sym;
  logic [LenW-1:0] new_len;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    extend = run_open_r && (in_ch.in_char == run_sym_r) && (run_len_r < LenW'(MaxRun));
    if (extend) begin
      new_sym = run_sym_r;
      new_len = run_len_r + LenW'(1);
    end else begin
      new_sym = in_ch.in_char;
      new_len = LenW'(1);
    end

    q_cmd.close_v   = run_open_r && !extend;
    q_cmd.close_sym = run_sym_r;
    q_cmd.close_len = DecW'(run_len_r);
    q_cmd.fin_v     = in_ch.in_last;
    q_cmd.fin_sym   = new_sym;
    q_cmd.fin_len   = DecW'(new_len);

    q_push = accept && (q_cmd.close_v || q_cmd.fin_v);

    run_sym_nxt  = run_sym_r;
    run_len_nxt  = run_len_r;
    run_open_nxt = run_open_r;
    if (accept) begin
      if (in_ch.in_last) begin
        run_sym_nxt  = '0;
        run_len_nxt  = '0;
        run_open_nxt = 1'b0;
      end else begin
        run_sym_nxt  = new_sym;
        run_len_nxt  = new_len;
        run_open_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sym_r  <= '0;
      run_len_r  <= '0;
      run_open_r <= 1'b0;
    end else begin
      run_sym_r  <= run_sym_nxt;
      run_len_r  <= run_len_nxt;
      run_open_r <= run_open_nxt;
    end
  end

endmodule

// ----- hdl/txtrle_fifo.sv -----
module txtrle_fifo #(
  parameter int Depth = txtrle_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  txtrle_pkg::cmd_t    push_cmd,
  input  logic                pop,
  output txtrle_pkg::cmd_t    head_cmd,
  output txtrle_pkg::qstat_t  stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  txtrle_pkg::cmd_t mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CntW'(Depth));
  assign stat.empty = (cnt_r == '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/txtrle_back.sv -----
module txtrle_back (
  input  logic              clk,
  input  logic              rst_n,
  input  txtrle_pkg::cmd_t  cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  txtrle_out_if.source      out_ch
);

  localparam int DecW = txtrle_pkg::DEC_W;
  localparam int MulW = DecW + 4;

  localparam logic PH_SYM = 1'b0;
  localparam logic PH_DIG = 1'b1;

  logic            busy_r, busy_nxt;
  logic            phase_r, phase_nxt;
  logic [7:0]      sym_r, sym_nxt;
  logic [DecW-1:0] rem_r, rem_nxt;
  logic [2:0]      place_r, place_nxt;
  logic            end_r, end_nxt;
  logic            ilast_r, ilast_nxt;
  logic            pend_r, pend_nxt;
  logic [7:0]      pend_sym_r, pend_sym_nxt;
  logic [DecW-1:0] pend_len_r, pend_len_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      ob_r, ob_nxt;
  logic            ol_r, ol_nxt;
  logic            oe_r, oe_nxt;

  logic            advance;
  logic            finishing;
  logic            need_load;
  logic [DecW-1:0] pw;
  logic [MulW-1:0] mult [10];
  logic [3:0]      digit;

  assign advance   = !ov_r || out_ch.ready;
  assign finishing = busy_r && (phase_r == PH_DIG) && (place_r == 3'd0);
  assign need_load = !busy_r || (advance && finishing && !pend_r);
  assign cmd_pop   = need_load && !cmd_empty;

  // The current digit is the largest k with k * 10^place not above the remainder.
  always_comb begin
    pw    = txtrle_pkg::pow10(place_r);
    digit = 4'd0;
    for (int k = 0; k < 10; k++) begin
      mult[k] = MulW'(pw) * MulW'(k);
    end
    for (int k = 1; k < 10; k++) begin
      if (MulW'(rem_r) >= mult[k]) begin
        digit = 4'(k);
      end
    end
  end

  always_comb begin
    busy_nxt     = busy_r;
    phase_nxt    = phase_r;
    sym_nxt      = sym_r;
    rem_nxt      = rem_r;
    place_nxt    = place_r;
    end_nxt      = end_r;
    ilast_nxt    = ilast_r;
    pend_nxt     = pend_r;
    pend_sym_nxt = pend_sym_r;
    pend_len_nxt = pend_len_r;
    ov_nxt       = advance ? 1'b0 : ov_r;
    ob_nxt       = ob_r;
    ol_nxt       = ol_r;
    oe_nxt       = oe_r;

    if (busy_r && advance) begin
      ov_nxt = 1'b1;
      if (phase_r == PH_SYM) begin
        ob_nxt    = sym_r;
        ol_nxt    = 1'b0;
        oe_nxt    = 1'b0;
        phase_nxt = PH_DIG;
      end else begin
        ob_nxt  = txtrle_pkg::ASCII_ZERO + 8'(digit);
        ol_nxt  = finishing && ilast_r;
        oe_nxt  = finishing && end_r;
        rem_nxt = rem_r - DecW'(mult[digit]);
        if (place_r != 3'd0) begin
          place_nxt = place_r - 3'd1;
        end else if (pend_r) begin
          // The final run of the message follows the closed run of the same beat.
          sym_nxt   = pend_sym_r;
          rem_nxt   = pend_len_r;
          place_nxt = txtrle_pkg::lead_place(pend_len_r);
          phase_nxt = PH_SYM;
          ilast_nxt = 1'b1;
          end_nxt   = 1'b1;
          pend_nxt  = 1'b0;
        end else begin
          busy_nxt = 1'b0;
        end
      end
    end

    if (cmd_pop) begin
      busy_nxt     = 1'b1;
      phase_nxt    = PH_SYM;
      pend_sym_nxt = cmd.fin_sym;
      pend_len_nxt = cmd.fin_len;
      if (cmd.close_v) begin
        sym_nxt   = cmd.close_sym;
        rem_nxt   = cmd.close_len;
        place_nxt = txtrle_pkg::lead_place(cmd.close_len);
        ilast_nxt = !cmd.fin_v;
        end_nxt   = 1'b0;
        pend_nxt  = cmd.fin_v;
      end else begin
        sym_nxt   = cmd.fin_sym;
        rem_nxt   = cmd.fin_len;
        place_nxt = txtrle_pkg::lead_place(cmd.fin_len);
        ilast_nxt = 1'b1;
        end_nxt   = 1'b1;
        pend_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_SYM;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    rem_r      <= rem_nxt;
    place_r    <= place_nxt;
    end_r      <= end_nxt;
    ilast_r    <= ilast_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_len_r <= pend_len_nxt;
    ob_r       <= ob_nxt;
    ol_r       <= ol_nxt;
    oe_r       <= oe_nxt;
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.out_last = ol_r;
  assign out_ch.out_end  = oe_r;

endmodule

// ----- hdl/text_rle_encoder.sv -----
// Channel   Dir  Beat carries                     Handshake
// in_ch     in   in_char, in_last                 valid / ready
// out_ch    out  out_byte, out_last, out_end      valid / ready
//
// The front end takes one character every cycle while the command queue has room.
// The back end sends one byte per cycle while out_ch is ready: symbol, then digits.
// A closed run is registered in the queue, the back end's run state and the output.
// Reset is synchronous; nothing needs clearing afterwards, so input is taken at once.
// A stalled output holds the back end; the front stalls only when the queue is full.
module text_rle_encoder #(
  parameter int CountWidth = txtrle_pkg::COUNT_WIDTH,
  parameter int QueueDepth = txtrle_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  txtrle_in_if.sink      in_ch,
  txtrle_out_if.source   out_ch
);

  txtrle_pkg::cmd_t   push_cmd;
  txtrle_pkg::cmd_t   head_cmd;
  txtrle_pkg::qstat_t q_stat;
  logic               q_push;
  logic               q_pop;

  txtrle_front #(
    .CountWidth(CountWidth)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  txtrle_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  txtrle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head_cmd),
    .cmd_empty (q_stat.empty),
    .cmd_pop   (q_pop),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_push) else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("command popped from an empty queue");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_end) |-> out_ch.out_last)
    else $error("message end without end of beat results");

  a_push_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_stat.empty) else $error("queue empty right after a push");
`endif

endmodule

// ----- test/text_rle_encoder_test.sv -----
`timescale 1ns / 1ps

module text_rle_encoder_test;

  localparam int unsigned RUN_CAP =
    (txtrle_pkg::COUNT_WIDTH >= 17) ? txtrle_pkg::DIGIT_CAP
                                    : ((1 << txtrle_pkg::COUNT_WIDTH) - 1);
  localparam int RANDOM_ITEMS = 480;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 24;

  // Tracks the open run and the bytes still owed on the output channel.
  class encoded_byte_board;
    typedef struct packed {
      logic [7:0] data;
      logic       item_end;
      logic       msg_end;
    } enc_beat_t;

    enc_beat_t   pending_bytes[$];
    logic [7:0]  run_char;
    int unsigned run_len;
    bit          run_live;
    int unsigned run_cap;
    int          mismatches;

    function new(int unsigned cap);
      run_char   = '0;
      run_len    = 0;
      run_live   = 1'b0;
      run_cap    = cap;
      mismatches = 0;
    endfunction

    function void push_byte(logic [7:0] d);
      enc_beat_t b;
      b.data     = d;
      b.item_end = 1'b0;
      b.msg_end  = 1'b0;
      pending_bytes.push_back(b);
    endfunction

    // Run character followed by its length in decimal, no leading zeros.
    function void emit_run(logic [7:0] c, int unsigned n);
      string digits;
      digits = $sformatf("%0d", n);
      push_byte(c);
      for (int i = 0; i < digits.len(); i++) begin
        push_byte(digits[i]);
      end
    endfunction

    function void take_char(logic [7:0] c, logic last);
      int before_cnt;
      before_cnt = pending_bytes.size();
      if (run_live && c == run_char && run_len < run_cap) begin
        run_len++;
      end else begin
        if (run_live) begin
          emit_run(run_char, run_len);
        end
        run_char = c;
        run_len  = 1;
        run_live = 1'b1;
      end
      if (last) begin
        emit_run(run_char, run_len);
        pending_bytes[pending_bytes.size() - 1].msg_end = 1'b1;
        run_char = '0;
        run_len  = 0;
        run_live = 1'b0;
      end
      if (pending_bytes.size() > before_cnt) begin
        pending_bytes[pending_bytes.size() - 1].item_end = 1'b1;
      end
    endfunction

    function void check_byte(logic [7:0] data, logic item_end, logic msg_end);
      enc_beat_t want;
      if (pending_bytes.size() == 0) begin
        $error("unexpected beat: out_byte=%h out_last=%b out_end=%b", data, item_end, msg_end);
        mismatches++;
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %h, got %h", want.data, data);
        mismatches++;
      end
      if (item_end !== want.item_end) begin
        $error("out_last: expected %b, got %b", want.item_end, item_end);
        mismatches++;
      end
      if (msg_end !== want.msg_end) begin
        $error("out_end: expected %b, got %b", want.msg_end, msg_end);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  txtrle_in_if  in_bus ();
  txtrle_out_if out_bus ();

  text_rle_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  encoded_byte_board board = new(RUN_CAP);

  int items_sent;
  int idle_cycles;
  int stretch_left [2];
  bit stretch_calm [2];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.in_char = '0;
    in_bus.in_last = 1'b0;
    out_bus.ready  = 1'b0;
    stretch_left   = '{0, 0};
    stretch_calm   = '{1'b0, 1'b0};
    items_sent     = 0;
    idle_cycles    = 0;
  end

  // Side 0 is the sender, side 1 the receiver. Waits come in stretches, some
  // of which have no idling at all.
  function automatic int draw_wait(int side);
    if (stretch_left[side] == 0) begin
      stretch_left[side] = $urandom_range(8, 40);
      stretch_calm[side] = ($urandom_range(0, 2) == 0);
    end
    stretch_left[side]--;
    return stretch_calm[side] ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.in_char <= c;
    in_bus.in_last <= last;
    do @(posedge clk); while (!in_bus.ready);
    board.take_char(c, last);
    items_sent++;
  endtask

  // Sends n copies of c; the final one ends the message when close_msg is set.
  task automatic send_run(input logic [7:0] c, input int n, input bit close_msg,
                          input bit fast);
    for (int i = 0; i < n; i++) begin
      send_char(c, close_msg && (i == n - 1), fast ? 0 : draw_wait(0));
    end
  endtask

  // The sender drops valid first so the last beat is not taken twice.
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int         stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(negedge clk);
      stall = draw_wait(1);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      board.check_byte(out_bus.out_byte, out_bus.out_last, out_bus.out_end);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[text_rle_encoder] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] alpha [3];
    logic [7:0] c;
    int         nruns;
    int         n;
    int         pick;
    int         msg_no;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-character messages at both ends of the byte range.
    send_run(8'h00, 1, 1'b1, 1'b0);
    send_run(8'hFF, 1, 1'b1, 1'b0);
    // Runs that close on a new character, and a last beat extending its run.
    send_run("a", 3, 1'b0, 1'b0);
    send_run("b", 1, 1'b0, 1'b0);
    send_run("a", 2, 1'b1, 1'b0);
    // Last beat with a different character closes two runs at once.
    send_run("q", 12, 1'b0, 1'b1);
    send_run("1", 1, 1'b1, 1'b0);
    send_run(8'h80, 9, 1'b0, 1'b0);
    send_run(8'h7F, 10, 1'b1, 1'b0);
    wait_drained();

    msg_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      for (int k = 0; k < 3; k++) begin
        alpha[k] = $urandom_range(0, 255);
      end
      nruns = $urandom_range(1, 6);
      for (int r = 0; r < nruns; r++) begin
        c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : alpha[$urandom_range(0, 2)];
        pick = $urandom_range(0, 39);
        if (pick < 30) begin
          n = $urandom_range(1, 4);
        end else if (pick < 38) begin
          n = $urandom_range(5, 15);
        end else begin
          n = $urandom_range(90, 110);
        end
        send_run(c, n, r == nruns - 1, 1'b0);
      end
      msg_no++;
      if (msg_no % 12 == 11) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("[text_rle_encoder] OK");
    end else begin
      $display("[text_rle_encoder] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/txtrle_pkg.sv
hdl/txtrle_if.sv
hdl/txtrle_front.sv
hdl/txtrle_fifo.sv
hdl/txtrle_back.sv
hdl/text_rle_encoder.sv
test/text_rle_encoder_test.sv
